[design/cps_pkg.sv]
// Package for the process scheduler: payload structs, record type and shared constants.
// Used by cps_ctrl, cps_dp and cpu_process_scheduler; depends on nothing.
package cps_pkg;

  localparam int QueueDepthDef = 16;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SRTF = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;
  localparam logic [1:0] POL_PRIO = 2'd3;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [15:0] QuantumReset = 16'd8;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  proc_id;
    logic [7:0]  proc_priority;
    logic [15:0] burst_time;
    logic        cpu_idle;
    logic [15:0] running_left;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        dispatched;
    logic [7:0]  new_id;
    logic [15:0] new_left;
    logic        preempted;
    logic [7:0]  old_id;
    logic [15:0] old_switches;
    logic [4:0]  queue_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] left;
    logic [15:0] sw;
  } rec_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic append;    // write arrival at tail
    logic scan_init; // start a scan pass at index 0
    logic scan_step; // evaluate the entry read last cycle
    logic rot_init;  // start the rotation pass
    logic rot_step;  // evaluate one rotation entry
    logic sel_read;  // read the selected entry
    logic shift_init;
    logic shift_step; // move one entry down
    logic finish;    // commit runner, push old runner, build result
    logic tick_only; // result without dispatch
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic full;
    logic empty;
    logic scan_done;
    logic rot_needed;
    logic rot_done;
    logic pick;
    logic shift_done;
  } sts_t;

endpackage

[design/cps_dp.sv]
// Datapath of the scheduler: ready-queue memory, runner record, slice timer, scan units.
// Depends on cps_pkg; driven by cps_ctrl through cps_pkg::cmd_t.
module cps_dp #(
  parameter int QUEUE_DEPTH = cps_pkg::QueueDepthDef,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cps_pkg::in_item_t   item,
  input  logic [1:0]          policy,
  input  logic [15:0]         quantum,
  input  cps_pkg::cmd_t       cmd,
  output cps_pkg::sts_t       sts,
  output cps_pkg::out_item_t  result
);

  cps_pkg::rec_t mem [QUEUE_DEPTH];
  cps_pkg::rec_t rd_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  cps_pkg::rec_t wr_data;

  cps_pkg::in_item_t it_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  cps_pkg::rec_t run_r, run_nxt;
  cps_pkg::rec_t chosen_r, chosen_nxt;
  logic          run_v_r, run_v_nxt;
  logic [15:0]   slice_r, slice_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // entry index under evaluation
  logic [CW-1:0] k_r, k_nxt;         // rotation step counter
  logic [IW-1:0] sel_r, sel_nxt;
  logic          pick_r, pick_nxt;
  logic [16:0]   best_r, best_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic          rot_r, rot_nxt;
  cps_pkg::out_item_t res_r, res_nxt;

  logic busy;
  logic [15:0] slice_dec;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] rot_idx;

  assign busy      = !it_r.cpu_idle && run_v_r;
  assign slice_dec = (slice_r != 16'd0) ? slice_r - 16'd1 : slice_r;
  assign cnt_m1    = cnt_r - CW'(1);

  // Rotation visit order: from head, or just after the runner's own entry.
  always_comb begin
    logic [CW:0] s;
    s = {1'b0, start_r} + {1'b0, k_nxt};
    if (start_r == cnt_r) rot_idx = k_nxt - CW'(1);
    else if (s >= {1'b0, cnt_r}) rot_idx = CW'(s - {1'b0, cnt_r});
    else rot_idx = s[CW-1:0];
  end

  always_comb begin
    rd_addr = idx_nxt[IW-1:0];
    if (cmd.rot_init || cmd.rot_step) rd_addr = rot_idx[IW-1:0];
    if (cmd.sel_read) rd_addr = sel_r;
  end

  always_comb begin
    cnt_nxt = cnt_r; run_nxt = run_r; run_v_nxt = run_v_r; slice_nxt = slice_r;
    idx_nxt = idx_r; k_nxt = k_r; sel_nxt = sel_r; pick_nxt = pick_r;
    best_nxt = best_r; start_nxt = start_r; rot_nxt = rot_r; res_nxt = res_r;
    chosen_nxt = chosen_r;
    wr_en = 1'b0; wr_addr = cnt_r[IW-1:0]; wr_data = '0;

    if (cmd.append) begin
      res_nxt = '0;
      if (cnt_r != CW'(QUEUE_DEPTH)) begin
        wr_en   = 1'b1;
        wr_data = '{id: it_r.proc_id, prio: it_r.proc_priority,
                    left: it_r.burst_time, sw: 16'd0};
        cnt_nxt = cnt_r + CW'(1);
        res_nxt.accepted = 1'b1;
      end
      res_nxt.queue_count = 5'(cnt_nxt);
    end

    if (cmd.scan_init) begin
      slice_nxt = slice_dec;
      idx_nxt = '0; sel_nxt = '0; rot_nxt = 1'b0;
      start_nxt = cnt_r;
      unique case (policy)
        cps_pkg::POL_FCFS: begin pick_nxt = !busy; best_nxt = '0; end
        cps_pkg::POL_SRTF: begin
          pick_nxt = !busy;
          best_nxt = busy ? {1'b0, it_r.running_left} : 17'h1FFFF;
        end
        cps_pkg::POL_RR: begin
          pick_nxt = !busy || slice_dec == 16'd0;
          if (pick_nxt) slice_nxt = quantum;
          best_nxt = '0;
        end
        default: begin
          pick_nxt = 1'b0;
          best_nxt = busy ? {9'd0, run_r.prio} : 17'd256;
        end
      endcase
    end

    // rd_r holds entry idx_r during a scan step.
    if (cmd.scan_step) begin
      unique case (policy)
        cps_pkg::POL_SRTF:
          if ({1'b0, rd_r.left} < best_r) begin
            best_nxt = {1'b0, rd_r.left}; pick_nxt = 1'b1; sel_nxt = idx_r[IW-1:0];
          end
        cps_pkg::POL_PRIO: begin
          if ({9'd0, rd_r.prio} < best_r) begin
            best_nxt = {9'd0, rd_r.prio}; pick_nxt = 1'b1; sel_nxt = idx_r[IW-1:0];
          end
          if (busy && rd_r.id == run_r.id && start_r == cnt_r) start_nxt = idx_r;
        end
        default: ;
      endcase
      idx_nxt = idx_r + CW'(1);
      if (idx_nxt == cnt_r && policy == cps_pkg::POL_PRIO) begin
        if (pick_nxt) slice_nxt = quantum;
        else if (!busy || slice_r == 16'd0) rot_nxt = 1'b1;
      end
    end

    if (cmd.rot_init) begin
      k_nxt = CW'(1);
      best_nxt = busy ? {9'd0, run_r.prio} : 17'd0;
      slice_nxt = quantum;
    end
    if (cmd.rot_step) begin
      // rd_r holds the entry of rotation step k_r; the read for the next step starts now.
      if (!busy && k_r == CW'(1)) best_nxt = {9'd0, rd_r.prio};
      if (rd_r.prio == (!busy && k_r == CW'(1) ? rd_r.prio : best_r[7:0])) begin
        pick_nxt = 1'b1; sel_nxt = idx_r[IW-1:0];
      end
      k_nxt = k_r + CW'(1);
    end

    if (cmd.shift_init) begin
      idx_nxt = CW'(sel_r) + CW'(1);
      res_nxt = '0;
      res_nxt.dispatched = 1'b1;
      res_nxt.new_id = rd_r.id;
      res_nxt.new_left = rd_r.left;
      chosen_nxt = rd_r;
    end
    if (cmd.shift_step) begin
      wr_en = 1'b1; wr_addr = IW'(idx_r - CW'(1)); wr_data = rd_r;
      idx_nxt = idx_r + CW'(1);
    end

    if (cmd.finish) begin
      cnt_nxt = cnt_m1;
      run_nxt = chosen_r;
      run_v_nxt = 1'b1;
      if (busy) begin
        wr_en = 1'b1; wr_addr = cnt_m1[IW-1:0];
        wr_data = '{id: run_r.id, prio: run_r.prio, left: it_r.running_left,
                    sw: run_r.sw + 16'd1};
        cnt_nxt = cnt_r;
        res_nxt.preempted = 1'b1;
        res_nxt.old_id = run_r.id;
        res_nxt.old_switches = run_r.sw + 16'd1;
      end
      res_nxt.queue_count = 5'(cnt_nxt);
    end

    if (cmd.tick_only) begin
      if (cnt_r == '0) slice_nxt = slice_dec;
      res_nxt = '0;
      res_nxt.queue_count = 5'(cnt_r);
    end
  end

  // idx_r tracks the rotation index so that sel captures the visited entry.
  logic [CW-1:0] idx_use;
  assign idx_use = (cmd.rot_init || cmd.rot_step) ? rot_idx : idx_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; run_r <= '0; run_v_r <= 1'b0; slice_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; run_r <= run_nxt; run_v_r <= run_v_nxt; slice_r <= slice_nxt;
    end
    if (cmd.load) it_r <= item;
    idx_r <= idx_use; k_r <= k_nxt; sel_r <= sel_nxt; pick_r <= pick_nxt;
    best_r <= best_nxt; start_r <= start_nxt; rot_r <= rot_nxt; res_r <= res_nxt;
    chosen_r <= chosen_nxt;
  end

  always_comb begin
    sts.req_tick   = it_r.req_type;
    sts.full       = cnt_r == CW'(QUEUE_DEPTH);
    sts.empty      = cnt_r == '0;
    sts.scan_done  = idx_r == cnt_r;
    sts.rot_needed = rot_r;
    sts.rot_done   = k_r == cnt_r + CW'(1);
    sts.pick       = pick_r;
    sts.shift_done = idx_r == cnt_r;
  end
  assign result = res_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append && cnt_r == CW'(QUEUE_DEPTH) |-> !wr_en) else $error("write to full queue");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> run_v_r) else $error("runner not valid after dispatch");
`endif
endmodule

[design/cps_ctrl.sv]
// Controller of the scheduler: sequences append, scan, rotation, removal shift and result.
// Depends on cps_pkg; talks to cps_dp through cps_pkg::cmd_t and cps_pkg::sts_t.
module cps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cps_pkg::sts_t sts,
  output cps_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN, S_ROT_RD, S_ROT, S_SEL_RD, S_SEL,
    S_SHIFT, S_FINISH, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_nxt = S_DECODE; end
      S_DECODE: begin
        if (!sts.req_tick) begin
          cmd.append = 1'b1; state_nxt = S_OUT; out_valid_nxt = 1'b1;
        end else if (sts.empty) begin
          cmd.tick_only = 1'b1; state_nxt = S_OUT; out_valid_nxt = 1'b1;
        end else begin
          cmd.scan_init = 1'b1; state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_ROT_RD;
        else cmd.scan_step = 1'b1;
      end
      S_ROT_RD: begin
        if (sts.rot_needed) begin cmd.rot_init = 1'b1; state_nxt = S_ROT; end
        else state_nxt = S_SEL_RD;
      end
      S_ROT: begin
        if (sts.rot_done || sts.pick) state_nxt = S_SEL_RD;
        else cmd.rot_step = 1'b1;
      end
      S_SEL_RD: begin
        if (sts.pick) begin cmd.sel_read = 1'b1; state_nxt = S_SEL; end
        else begin cmd.tick_only = 1'b1; state_nxt = S_OUT; out_valid_nxt = 1'b1; end
      end
      S_SEL: begin cmd.shift_init = 1'b1; state_nxt = S_SHIFT; end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_FINISH;
        else cmd.shift_step = 1'b1;
      end
      S_FINISH: begin cmd.finish = 1'b1; state_nxt = S_OUT; out_valid_nxt = 1'b1; end
      S_OUT: if (out_ready) begin state_nxt = S_IDLE; out_valid_nxt = 1'b0; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result shown outside output state");
  a_one_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r) else $error("input taken while result pending");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready |=> state_r == S_IDLE) else $error("no return to idle");
`endif
endmodule

[design/cpu_process_scheduler.sv]
// Top level of the ready-queue process scheduler: config registers, controller, datapath.
// Depends on cps_pkg, cps_ctrl and cps_dp.
//
//  channel | signals                        | role
//  in      | in_valid in_ready in_data      | arrival or tick item
//  out     | out_valid out_ready out_data   | one result item per input item
//  cfg     | cfg_we cfg_index cfg_data      | policy_mode, time_quantum
//
// An arrival, or a tick on an empty queue, is done at decode. A tick with N queued
// entries runs one scan pass over the one-read, one-write queue memory, an optional
// rotation pass, and on dispatch a shift pass that closes the gap behind the pick.
// One item is in work at a time; a waiting result holds the input side.
// Reset is synchronous and needs no clearing pass.
module cpu_process_scheduler #(
  parameter int QUEUE_DEPTH = cps_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cps_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [1:0]    policy_r;
  logic [15:0]   quantum_r;
  cps_pkg::cmd_t cmd;
  cps_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= cps_pkg::POL_FCFS; quantum_r <= cps_pkg::QuantumReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cps_pkg::CFG_POLICY:  policy_r  <= cfg_data[1:0];
        cps_pkg::CFG_QUANTUM: quantum_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  cps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .item(in_data), .policy(policy_r), .quantum(quantum_r),
    .cmd, .sts, .result(out_data)
  );

endmodule
